>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check, also active while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/rrbm_pkg.sv
package rrbm_pkg;

  // Result target codes.
  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2
  } target_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ROM_COUNT = 2'd0,
    CFG_RAM_COUNT = 2'd1,
    CFG_HAS_RAM   = 2'd2
  } cfg_idx_e;

  localparam int unsigned CmdW      = 1;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned MemAddrW  = 23;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned RomCountW = 10;
  localparam int unsigned RamCountW = 5;
  localparam int unsigned RomBankW  = 9;
  localparam int unsigned RamBankW  = 4;

  // Access kind codes.
  localparam logic [CmdW-1:0] CmdRead  = 1'b0;
  localparam logic [CmdW-1:0] CmdWrite = 1'b1;

  // Upper address nibble decode.
  localparam logic [3:0] RegionRamEnLo = 4'h0;
  localparam logic [3:0] RegionRamEnHi = 4'h1;
  localparam logic [3:0] RegionRomLo   = 4'h2;
  localparam logic [3:0] RegionRomHi   = 4'h3;
  localparam logic [3:0] RegionRamSelA = 4'h4;
  localparam logic [3:0] RegionRamSelB = 4'h5;
  localparam logic [3:0] RegionCartA   = 4'hA;
  localparam logic [3:0] RegionCartB   = 4'hB;

  localparam logic [DataW-1:0]    RamEnableKey = 8'h0A;
  localparam logic [RomBankW-1:0] RomBankReset = 9'd1;

endpackage

>>> src/rrbm_if.sv
// Access request channel.
interface rrbm_req_if;
  logic                          valid;
  logic                          ready;
  logic [rrbm_pkg::CmdW-1:0]     cmd;
  logic [rrbm_pkg::AddrW-1:0]    addr;
  logic [rrbm_pkg::DataW-1:0]    data;

  modport source (output valid, cmd, addr, data, input ready);
  modport sink   (input valid, cmd, addr, data, output ready);
endinterface

// Translated access channel.
interface rrbm_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     target;
  logic [rrbm_pkg::MemAddrW-1:0]  mem_addr;
  logic                           mem_write;
  logic [rrbm_pkg::DataW-1:0]     write_data;

  modport source (output valid, target, mem_addr, mem_write, write_data, input ready);
  modport sink   (input valid, target, mem_addr, mem_write, write_data, output ready);
endinterface

// Configuration write channel.
interface rrbm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rrbm_pkg::CfgIdxW-1:0]   index;
  logic [rrbm_pkg::CfgDataW-1:0]  wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

>>> src/rom_ram_bank_mapper_core.sv
// Channel  Dir  Beat contents                          Accepted when
// -------  ---  -------------------------------------  --------------------
// req      in   cmd, addr, data                        req.valid & req.ready
// rsp      out  target, mem_addr, mem_write, write_data rsp.valid & rsp.ready
// cfg      in   index, wdata                           cfg.valid (ready tied high)
//
// A read, a RAM-enable write or any other non-bank access has its result land in the
// output register at the accepting edge. A bank-select write posts its result (all zero)
// at once while the shared restoring remainder unit runs one bank bit per cycle; req.ready
// stays low until the new bank is stored.
// req.ready also needs the output register free or being drained in the same cycle.
// rst_ni is asynchronous, active low; it restores bank state and config defaults.
`include "assert_macros.svh"

module rom_ram_bank_mapper_core #(
  parameter int unsigned MAX_ROM_BANKS = 512,
  parameter int unsigned MAX_RAM_BANKS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrbm_req_if.sink   req,
  rrbm_rsp_if.source rsp,
  rrbm_cfg_if.sink   cfg
);

  // Divisor width covers the larger of the two bank maxima.
  localparam int unsigned MaxBanks = (MAX_ROM_BANKS > MAX_RAM_BANKS) ?
                                     MAX_ROM_BANKS : MAX_RAM_BANKS;
  localparam int unsigned DivW     = $clog2(MaxBanks + 1);
  localparam int unsigned StepW    = $clog2(rrbm_pkg::RomBankW);
  localparam logic [StepW-1:0] LastStep = StepW'(rrbm_pkg::RomBankW - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Config registers.
  logic [rrbm_pkg::RomCountW-1:0] rom_cnt_q;
  logic [rrbm_pkg::RamCountW-1:0] ram_cnt_q;
  logic                           has_ram_q;

  // Bank state.
  logic                          ram_on_q, ram_on_d;
  logic [rrbm_pkg::RomBankW-1:0] rom_sel_q, rom_sel_d;
  logic [rrbm_pkg::RamBankW-1:0] ram_sel_q, ram_sel_d;

  // Shared remainder unit.
  logic [DivW-1:0]               div_q, div_d;
  logic [DivW-1:0]               rem_q, rem_d;
  logic [rrbm_pkg::RomBankW-1:0] dvd_q, dvd_d;
  logic [StepW-1:0]              step_q, step_d;
  logic                          to_ram_q, to_ram_d;
  logic [DivW:0]                 trial;
  logic [DivW-1:0]               rem_next;

  // Output register.
  logic                           out_vld_q, out_vld_d;
  rrbm_pkg::target_e              out_tgt_q, out_tgt_d;
  logic [rrbm_pkg::MemAddrW-1:0]  out_addr_q, out_addr_d;
  logic                           out_wr_q, out_wr_d;
  logic [rrbm_pkg::DataW-1:0]     out_data_q, out_data_d;

  logic                           req_fire;
  logic                           cfg_fire;
  logic [3:0]                     region;
  logic                           cart_hit;
  logic                           is_wr;
  logic [DivW-1:0]                rom_div;
  logic [DivW-1:0]                ram_div;
  logic [rrbm_pkg::RomCountW-1:0] rom_eff;
  logic [rrbm_pkg::RamCountW-1:0] ram_eff;

  assign req.ready = (state_q == ST_IDLE) && (!out_vld_q || rsp.ready);
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;

  assign rsp.valid      = out_vld_q;
  assign rsp.target     = out_tgt_q;
  assign rsp.mem_addr   = out_addr_q;
  assign rsp.mem_write  = out_wr_q;
  assign rsp.write_data = out_data_q;

  assign region   = req.addr[15:12];
  assign is_wr    = (req.cmd == rrbm_pkg::CmdWrite);
  assign cart_hit = ((region == rrbm_pkg::RegionCartA) || (region == rrbm_pkg::RegionCartB))
                    && has_ram_q && ram_on_q;

  // Clamp counts: zero acts as one, above max acts as max.
  always_comb begin
    priority if (rom_cnt_q == '0) begin
      rom_eff = rrbm_pkg::RomCountW'(1);
    end else if (rom_cnt_q > rrbm_pkg::RomCountW'(MAX_ROM_BANKS)) begin
      rom_eff = rrbm_pkg::RomCountW'(MAX_ROM_BANKS);
    end else begin
      rom_eff = rom_cnt_q;
    end
    priority if (ram_cnt_q == '0) begin
      ram_eff = rrbm_pkg::RamCountW'(1);
    end else if (ram_cnt_q > rrbm_pkg::RamCountW'(MAX_RAM_BANKS)) begin
      ram_eff = rrbm_pkg::RamCountW'(MAX_RAM_BANKS);
    end else begin
      ram_eff = ram_cnt_q;
    end
  end

  assign rom_div = DivW'(rom_eff);
  assign ram_div = DivW'(ram_eff);

  // One restoring step: shift in the next bank bit, subtract if it fits.
  assign trial    = {rem_q, dvd_q[rrbm_pkg::RomBankW-1]};
  assign rem_next = (trial >= {1'b0, div_q}) ? DivW'(trial - {1'b0, div_q}) : DivW'(trial);

  always_comb begin
    state_d    = state_q;
    ram_on_d   = ram_on_q;
    rom_sel_d  = rom_sel_q;
    ram_sel_d  = ram_sel_q;
    div_d      = div_q;
    rem_d      = rem_q;
    dvd_d      = dvd_q;
    step_d     = step_q;
    to_ram_d   = to_ram_q;
    out_vld_d  = out_vld_q && !rsp.ready;
    out_tgt_d  = out_tgt_q;
    out_addr_d = out_addr_q;
    out_wr_d   = out_wr_q;
    out_data_d = out_data_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          out_vld_d  = 1'b1;
          out_tgt_d  = rrbm_pkg::TGT_NONE;
          out_addr_d = '0;
          out_wr_d   = 1'b0;
          out_data_d = '0;
          rem_d      = '0;
          step_d     = '0;

          if (is_wr) begin
            unique case (region)
              rrbm_pkg::RegionRamEnLo, rrbm_pkg::RegionRamEnHi: begin
                ram_on_d = (req.data == rrbm_pkg::RamEnableKey);
              end
              rrbm_pkg::RegionRomLo: begin
                dvd_d    = {rom_sel_q[8], req.data};
                div_d    = rom_div;
                to_ram_d = 1'b0;
                state_d  = ST_DIV;
              end
              rrbm_pkg::RegionRomHi: begin
                dvd_d    = {req.data[0], rom_sel_q[7:0]};
                div_d    = rom_div;
                to_ram_d = 1'b0;
                state_d  = ST_DIV;
              end
              rrbm_pkg::RegionRamSelA, rrbm_pkg::RegionRamSelB: begin
                if (has_ram_q) begin
                  dvd_d    = {5'd0, req.data[3:0]};
                  div_d    = ram_div;
                  to_ram_d = 1'b1;
                  state_d  = ST_DIV;
                end
              end
              default: begin
              end
            endcase
          end else if (!req.addr[15] && !req.addr[14]) begin
            out_tgt_d  = rrbm_pkg::TGT_ROM;
            out_addr_d = {9'd0, req.addr[13:0]};
          end else if (!req.addr[15]) begin
            out_tgt_d  = rrbm_pkg::TGT_ROM;
            out_addr_d = {rom_sel_q, req.addr[13:0]};
          end

          if (cart_hit) begin
            out_tgt_d  = rrbm_pkg::TGT_RAM;
            out_addr_d = {6'd0, ram_sel_q, req.addr[12:0]};
            out_wr_d   = is_wr;
            out_data_d = is_wr ? req.data : '0;
          end
        end
      end
      ST_DIV: begin
        rem_d  = rem_next;
        dvd_d  = {dvd_q[rrbm_pkg::RomBankW-2:0], 1'b0};
        step_d = step_q + StepW'(1);
        if (step_q == LastStep) begin
          if (to_ram_q) begin
            ram_sel_d = rrbm_pkg::RamBankW'(rem_next);
          end else begin
            rom_sel_d = rrbm_pkg::RomBankW'(rem_next);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rom_cnt_q <= rrbm_pkg::RomCountW'(2);
      ram_cnt_q <= rrbm_pkg::RamCountW'(1);
      has_ram_q <= 1'b0;
      ram_on_q  <= 1'b0;
      rom_sel_q <= rrbm_pkg::RomBankReset;
      ram_sel_q <= '0;
      out_vld_q <= 1'b0;
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      ram_on_q  <= ram_on_d;
      rom_sel_q <= rom_sel_d;
      ram_sel_q <= ram_sel_d;
      out_vld_q <= out_vld_d;
      step_q    <= step_d;
      if (cfg_fire) begin
        unique case (cfg.index)
          rrbm_pkg::CFG_ROM_COUNT: rom_cnt_q <= cfg.wdata;
          rrbm_pkg::CFG_RAM_COUNT: ram_cnt_q <= cfg.wdata[rrbm_pkg::RamCountW-1:0];
          rrbm_pkg::CFG_HAS_RAM:   has_ram_q <= cfg.wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath, no reset.
  always_ff @(posedge clk_i) begin
    div_q      <= div_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    to_ram_q   <= to_ram_d;
    out_tgt_q  <= out_tgt_d;
    out_addr_q <= out_addr_d;
    out_wr_q   <= out_wr_d;
    out_data_q <= out_data_d;
  end

  `ASSERT_CLK(a_ready_only_idle, req.ready |-> (state_q == ST_IDLE), "ready while dividing")
  `ASSERT_CLK(a_rem_below_div, (state_q == ST_DIV) |-> (rem_q < div_q),
              "remainder not below divisor")
  `ASSERT_CLK(a_step_bound, (state_q == ST_DIV) |-> (step_q <= LastStep),
              "step counter overrun")
  `ASSERT_CLK(a_ram_sel_needs_ram, !$stable(ram_sel_q) |-> $past(has_ram_q),
              "RAM bank changed without RAM")

endmodule

>>> tb/rom_ram_bank_mapper_core_test.sv
`timescale 1ns / 1ps

module rom_ram_bank_mapper_core_test;

  localparam int unsigned MaxRomBanks    = 512;
  localparam int unsigned MaxRamBanks    = 16;
  localparam int unsigned BankCycles     = 10;   // bank write: acceptance, then 9 remainder steps
  localparam int unsigned HoldCycles     = 80;   // long receiver hold-off
  localparam int unsigned QuietLimit     = 3000; // cycles with no beat on any channel
  localparam int unsigned RandomPerPhase = 250;
  localparam int unsigned NumPhases      = 6;

  typedef struct {
    rrbm_pkg::target_e                target;
    logic [rrbm_pkg::MemAddrW-1:0]    mem_addr;
    logic                             mem_write;
    logic [rrbm_pkg::DataW-1:0]       write_data;
  } mapped_access_t;

  // Bank controller model plus the queue of translated accesses still owed by the block.
  class bank_map_board;
    logic [rrbm_pkg::RomCountW-1:0] rom_count;
    logic [rrbm_pkg::RamCountW-1:0] ram_count;
    logic                           ram_present;
    logic                           ram_live;
    logic [rrbm_pkg::RomBankW-1:0]  rom_pick;
    logic [rrbm_pkg::RamBankW-1:0]  ram_pick;
    mapped_access_t                 owed[$];
    int unsigned                    failures;

    function new();
      rom_count   = 10'd2;
      ram_count   = 5'd1;
      ram_present = 1'b0;
      ram_live    = 1'b0;
      rom_pick    = rrbm_pkg::RomBankReset;
      ram_pick    = '0;
      failures    = 0;
    endfunction

    function void set_reg(rrbm_pkg::cfg_idx_e idx, logic [rrbm_pkg::CfgDataW-1:0] value);
      case (idx)
        rrbm_pkg::CFG_ROM_COUNT: rom_count   = value[rrbm_pkg::RomCountW-1:0];
        rrbm_pkg::CFG_RAM_COUNT: ram_count   = value[rrbm_pkg::RamCountW-1:0];
        rrbm_pkg::CFG_HAS_RAM:   ram_present = value[0];
        default: ;
      endcase
    endfunction

    // Zero acts as one bank, anything past the build limit as the limit.
    function int unsigned bank_span(int unsigned n, int unsigned limit);
      if (n == 0) return 1;
      if (n > limit) return limit;
      return n;
    endfunction

    function void note_access(logic cmd, logic [rrbm_pkg::AddrW-1:0] addr,
                              logic [rrbm_pkg::DataW-1:0] data);
      logic [3:0]     region;
      int unsigned    bank;
      mapped_access_t m;
      region = addr[15:12];
      m.target     = rrbm_pkg::TGT_NONE;
      m.mem_addr   = '0;
      m.mem_write  = 1'b0;
      m.write_data = '0;
      if (cmd == rrbm_pkg::CmdWrite) begin
        case (region)
          rrbm_pkg::RegionRamEnLo, rrbm_pkg::RegionRamEnHi:
            ram_live = (data == rrbm_pkg::RamEnableKey);
          rrbm_pkg::RegionRomLo: begin
            bank     = int'({rom_pick[8], data});
            rom_pick = rrbm_pkg::RomBankW'(bank % bank_span(rom_count, MaxRomBanks));
          end
          rrbm_pkg::RegionRomHi: begin
            bank     = int'({data[0], rom_pick[7:0]});
            rom_pick = rrbm_pkg::RomBankW'(bank % bank_span(rom_count, MaxRomBanks));
          end
          rrbm_pkg::RegionRamSelA, rrbm_pkg::RegionRamSelB: begin
            if (ram_present) begin
              bank     = int'(data[3:0]);
              ram_pick = rrbm_pkg::RamBankW'(bank % bank_span(ram_count, MaxRamBanks));
            end
          end
          default: ;
        endcase
      end else if (region < 4'h4) begin
        m.target   = rrbm_pkg::TGT_ROM;
        m.mem_addr = rrbm_pkg::MemAddrW'(addr[13:0]);
      end else if (region < 4'h8) begin
        m.target   = rrbm_pkg::TGT_ROM;
        m.mem_addr = {rom_pick, addr[13:0]};
      end
      // cartridge RAM window, decided after any register update of this beat
      if ((region == rrbm_pkg::RegionCartA || region == rrbm_pkg::RegionCartB) &&
          ram_present && ram_live) begin
        m.target   = rrbm_pkg::TGT_RAM;
        m.mem_addr = rrbm_pkg::MemAddrW'({ram_pick, addr[12:0]});
        if (cmd == rrbm_pkg::CmdWrite) begin
          m.mem_write  = 1'b1;
          m.write_data = data;
        end
      end
      owed.push_back(m);
    endfunction

    task report(string msg);
      failures++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [1:0] target, logic [rrbm_pkg::MemAddrW-1:0] mem_addr,
                      logic mem_write, logic [rrbm_pkg::DataW-1:0] write_data);
      mapped_access_t m;
      if (owed.size() == 0) begin
        report($sformatf("result with nothing owed: target %0d addr %h", target, mem_addr));
        return;
      end
      m = owed.pop_front();
      if (target !== m.target)
        report($sformatf("target %0d, want %0d", target, m.target));
      if (mem_addr !== m.mem_addr)
        report($sformatf("mem_addr %h, want %h", mem_addr, m.mem_addr));
      if (mem_write !== m.mem_write)
        report($sformatf("mem_write %b, want %b", mem_write, m.mem_write));
      if (write_data !== m.write_data)
        report($sformatf("write_data %h, want %h", write_data, m.write_data));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   steady;    // no idling on either side while set
  bit   hold_rsp;  // asks the receiver for one long hold-off

  bank_map_board board = new();

  rrbm_req_if req_ch ();
  rrbm_rsp_if rsp_ch ();
  rrbm_cfg_if cfg_ch ();

  rom_ram_bank_mapper_core #(
    .MAX_ROM_BANKS(MaxRomBanks),
    .MAX_RAM_BANKS(MaxRamBanks)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch),
    .rsp   (rsp_ch),
    .cfg   (cfg_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Request side. A beat goes when valid and ready are both high before the edge;
  // valid is left high after a beat so back-to-back beats never toggle it.
  // ---------------------------------------------------------------------------
  task automatic send_access(logic cmd, logic [rrbm_pkg::AddrW-1:0] addr,
                             logic [rrbm_pkg::DataW-1:0] data);
    if (req_ch.valid !== 1'b1) req_ch.valid <= 1'b1;
    req_ch.cmd  <= cmd;
    req_ch.addr <= addr;
    req_ch.data <= data;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    board.note_access(cmd, addr, data);
  endtask

  task automatic pause_sender(int unsigned cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Always advances at least one edge, so valid never sees two updates in one step.
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (board.owed.size() != 0);
  endtask

  // Bank writes post their beat before the remainder unit finishes; give it time
  // before touching the counts.
  task automatic configure(logic [rrbm_pkg::CfgDataW-1:0] rom_v,
                           logic [rrbm_pkg::CfgDataW-1:0] ram_v,
                           logic [rrbm_pkg::CfgDataW-1:0] has_v);
    rrbm_pkg::cfg_idx_e            regs[3];
    logic [rrbm_pkg::CfgDataW-1:0] vals[3];
    regs = '{rrbm_pkg::CFG_ROM_COUNT, rrbm_pkg::CFG_RAM_COUNT, rrbm_pkg::CFG_HAS_RAM};
    vals = '{rom_v, ram_v, has_v};
    drain();
    repeat (BankCycles + 2) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_ch.index <= regs[i];
      cfg_ch.wdata <= vals[i];
      do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
      board.set_reg(regs[i], vals[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly bank-controller traffic: register writes, ROM reads and RAM window hits,
  // the rest anywhere on the bus.
  task automatic random_access();
    logic                        cmd;
    logic [rrbm_pkg::AddrW-1:0]  addr;
    logic [rrbm_pkg::DataW-1:0]  data;
    int unsigned                 pick;
    pick = $urandom_range(99);
    cmd  = 1'($urandom);
    addr = rrbm_pkg::AddrW'($urandom);
    data = rrbm_pkg::DataW'($urandom);
    if (pick < 10) begin
      cmd  = rrbm_pkg::CmdWrite;
      addr = {3'b000, 13'($urandom)};
      if ($urandom_range(1)) data = rrbm_pkg::RamEnableKey;
    end else if (pick < 22) begin
      cmd  = rrbm_pkg::CmdWrite;
      addr = {rrbm_pkg::RegionRomLo, 12'($urandom)};
    end else if (pick < 28) begin
      cmd  = rrbm_pkg::CmdWrite;
      addr = {rrbm_pkg::RegionRomHi, 12'($urandom)};
    end else if (pick < 36) begin
      cmd  = rrbm_pkg::CmdWrite;
      addr = {3'b010, 13'($urandom)};
    end else if (pick < 52) begin
      cmd      = rrbm_pkg::CmdRead;
      addr[15] = 1'b0;
    end else if (pick < 80) begin
      addr = {3'b101, 13'($urandom)};
    end
    send_access(cmd, addr, data);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stalls, one counted hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : rsp_side
    rsp_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= 7);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      board.check_result(rsp_ch.target, rsp_ch.mem_addr, rsp_ch.mem_write,
                         rsp_ch.write_data);
  end

  // Watchdog: a run with no beat anywhere for this long is hung.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("** rom_ram_bank_mapper_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [rrbm_pkg::CfgDataW-1:0] rom_set[NumPhases];
    logic [rrbm_pkg::CfgDataW-1:0] ram_set[NumPhases];
    logic [rrbm_pkg::CfgDataW-1:0] has_set[NumPhases];

    // full, past the limit, zero, minimum, random, odd
    rom_set = '{10'd512, 10'd1023, 10'd0, 10'd1, 10'd0, 10'd3};
    ram_set = '{10'd16, 10'd31, 10'd0, 10'd1, 10'd0, 10'd5};
    has_set = '{10'd1, 10'd1, 10'd1, 10'd0, 10'd0, 10'd1};
    rom_set[4] = rrbm_pkg::CfgDataW'($urandom_range(1, MaxRomBanks));
    ram_set[4] = rrbm_pkg::CfgDataW'($urandom_range(1, MaxRamBanks));
    has_set[4] = rrbm_pkg::CfgDataW'($urandom);  // only bit 0 counts

    rst_ni       = 1'b0;
    steady       = 1'b0;
    hold_rsp     = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.cmd   = rrbm_pkg::CmdRead;
    req_ch.addr  = '0;
    req_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = rrbm_pkg::CFG_ROM_COUNT;
    cfg_ch.wdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset counts: two ROM banks, no RAM. Address extremes, RAM window while absent.
    send_access(rrbm_pkg::CmdRead,  16'h0000, 8'h00);
    send_access(rrbm_pkg::CmdRead,  16'h3FFF, 8'hFF);
    send_access(rrbm_pkg::CmdRead,  16'h4000, 8'h00);  // reset bank 1
    send_access(rrbm_pkg::CmdRead,  16'h7FFF, 8'h00);
    send_access(rrbm_pkg::CmdRead,  16'h8000, 8'h00);
    send_access(rrbm_pkg::CmdWrite, 16'hFFFF, 8'hFF);
    send_access(rrbm_pkg::CmdWrite, 16'h0000, rrbm_pkg::RamEnableKey);
    send_access(rrbm_pkg::CmdRead,  16'hA000, 8'h00);  // enabled but absent
    send_access(rrbm_pkg::CmdWrite, 16'h4000, 8'h0F);  // RAM bank write without RAM
    send_access(rrbm_pkg::CmdWrite, 16'h2000, 8'hFF);  // wraps mod 2
    send_access(rrbm_pkg::CmdWrite, 16'h3000, 8'h01);
    send_access(rrbm_pkg::CmdRead,  16'h5ABC, 8'h00);

    for (int p = 0; p < NumPhases; p++) begin
      configure(rom_set[p], ram_set[p], has_set[p]);
      if (p == 0) begin
        // Full bank ranges with RAM fitted; first read still sees the old bank.
        send_access(rrbm_pkg::CmdRead,  16'h4000, 8'h00);
        send_access(rrbm_pkg::CmdWrite, 16'h2FFF, 8'hFF);
        send_access(rrbm_pkg::CmdWrite, 16'h3FFF, 8'h01);
        send_access(rrbm_pkg::CmdRead,  16'h7FFF, 8'h00);  // top of the ROM image
        send_access(rrbm_pkg::CmdWrite, 16'h1FFF, rrbm_pkg::RamEnableKey);
        send_access(rrbm_pkg::CmdWrite, 16'h5FFF, 8'hFF);
        send_access(rrbm_pkg::CmdRead,  16'hBFFF, 8'hFF);
        send_access(rrbm_pkg::CmdWrite, 16'hA000, 8'hA5);
        send_access(rrbm_pkg::CmdWrite, 16'h0000, 8'h0B);  // any other value disables
        send_access(rrbm_pkg::CmdRead,  16'hA000, 8'h00);
        send_access(rrbm_pkg::CmdWrite, 16'h6000, 8'h12);
        send_access(rrbm_pkg::CmdWrite, 16'h2000, 8'h00);  // bit 8 kept: bank 256 in the switchable window
        send_access(rrbm_pkg::CmdRead,  16'h4000, 8'h00);
      end
      steady = (p == 1);
      if (p == 2) hold_rsp = 1'b1;  // output backs up while requests keep coming
      for (int n = 0; n < RandomPerPhase; n++) begin
        if (p == 3 && n == RandomPerPhase / 2)
          drain();
        else if (!steady && $urandom_range(99) < 7)
          pause_sender($urandom_range(1, 4));
        random_access();
      end
    end

    drain();
    repeat (BankCycles * 2) @(posedge clk_i);
    if (board.owed.size() != 0)
      board.report($sformatf("%0d results never arrived", board.owed.size()));

    if (board.failures == 0) begin
      $display("** rom_ram_bank_mapper_core: PASSED **");
    end else begin
      $display("** rom_ram_bank_mapper_core: FAILED **");
    end
    $finish;
  end

endmodule
